FILE: rtl/core/greedy_word_wrap_top_assert.svh
// Assertion macros used by the checker file gww_checker.sv.
`ifndef GREEDY_WORD_WRAP_TOP_ASSERT_SVH
`define GREEDY_WORD_WRAP_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GWW_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("greedy word wrap check failed");

// next-cycle implication, disabled while in reset
`define GWW_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("greedy word wrap check failed");

`endif

FILE: rtl/core/gww_pkg.sv
package gww_pkg;

    localparam int MAX_WORD_DEF = 32;

    localparam logic [7:0] SPACE_BYTE     = 8'd32;
    localparam logic [7:0] BREAK_BYTE     = 8'd10;
    localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_SPACE,
        SEP_BREAK
    } t_sep;

    typedef struct packed {
        logic bank;
        t_sep sep;
        logic cut;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SEP,
        BS_WORD,
        BS_CLOSE
    } t_bstate;

endpackage

FILE: rtl/core/gww_if.sv
interface gww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       text_end;
    modport source (output valid, ch, text_end, input ready);
    modport sink   (input valid, ch, text_end, output ready);
endinterface

interface gww_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       word_cut;
    modport source (output valid, out_char, run_last, word_cut, input ready);
    modport sink   (input valid, out_char, run_last, word_cut, output ready);
endinterface

interface gww_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/greedy_word_wrap_top.sv
// channel  | dir | payload                       | request accepted when
// ---------+-----+-------------------------------+----------------------
// i_in     | in  | ch, text_end                  | valid && ready
// o_out    | out | out_char, run_last, word_cut  | valid && ready
// i_cfg    | in  | data (line_width)             | valid (ready tied high)
//
// Front takes one byte a cycle while its word bank is free and the queue has
// room; two banks let it fill the next word while the back still emits the
// previous one. Back: takes a request off the queue, then one result a cycle
// while the output is not stalled (separator, word bytes from the word RAM
// read port, closing break). Output register holds on stall.
// Reset clears control state only; the word RAM is not cleared.
module greedy_word_wrap_top #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gww_in_if.sink    i_in,
    gww_out_if.source o_out,
    gww_cfg_if.sink   i_cfg
);
    import gww_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = $clog2(2 * MAX_WORD);
    localparam int QW = $bits(t_cmd) + LW;

    logic          q_full, q_empty, push, pop;
    t_cmd          f_cmd, b_cmd;
    logic [LW-1:0] f_len, b_len;
    logic [QW-1:0] q_rdata;
    t_rel          rel;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    assign i_cfg.ready = 1'b1;

    gww_front #(.MAX_WORD(MAX_WORD)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_ch       (i_in.ch),
        .i_in_text_end (i_in.text_end),
        .o_in_ready    (i_in.ready),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (f_cmd),
        .o_cmd_len     (f_len),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_rel         (rel)
    );

    gww_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_len}),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_cmd, b_len} = q_rdata;

    gww_ram #(.WIDTH(8), .DEPTH(2 * MAX_WORD)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gww_back #(.MAX_WORD(MAX_WORD)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (b_cmd),
        .i_cmd_len      (b_len),
        .o_pop          (pop),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_char     (o_out.out_char),
        .o_out_run_last (o_out.run_last),
        .o_out_word_cut (o_out.word_cut),
        .o_rel          (rel)
    );

endmodule

FILE: rtl/core/gww_ram.sv
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/gww_front.sv
module gww_front #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF,
    localparam int LW = $clog2(MAX_WORD + 1),
    localparam int AW = $clog2(2 * MAX_WORD),
    localparam int SW = $clog2(255 + 1 + MAX_WORD + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_in_ch,
    input  logic             i_in_text_end,
    output logic             o_in_ready,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_q_full,
    output logic             o_push,
    output gww_pkg::t_cmd    o_cmd,
    output logic [LW-1:0]    o_cmd_len,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data,
    input  gww_pkg::t_rel    i_rel
);
    import gww_pkg::*;

    logic [7:0]    r_line_width;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_col, n_col;
    logic          r_ovf, n_ovf;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;

    logic          acc, is_sp, room, wr, ovf_after, flush, has_word, fits;
    logic [LW-1:0] len_after;
    logic [SW-1:0] sum;
    t_sep          sep;
    logic [7:0]    col_word;

    assign o_in_ready = !i_q_full && !r_busy[r_bank];
    assign acc        = i_in_valid && o_in_ready;
    assign is_sp      = (i_in_ch == SPACE_BYTE);
    assign room       = (r_len < LW'(MAX_WORD));
    assign wr         = !is_sp && room;
    assign len_after  = r_len + LW'(wr);
    assign ovf_after  = r_ovf | (!is_sp && !room);
    assign flush      = is_sp || i_in_text_end;
    assign has_word   = flush && (len_after != '0);
    assign sum        = SW'(r_col) + SW'(len_after) + SW'(1);
    assign fits       = (sum <= SW'(r_line_width));

    always_comb begin
        if (r_col == 8'd0) begin
            sep      = SEP_NONE;
            col_word = 8'(len_after);
        end else if (fits) begin
            sep      = SEP_SPACE;
            col_word = 8'(sum);
        end else begin
            sep      = SEP_BREAK;
            col_word = 8'(len_after);
        end
    end

    assign o_push       = acc && (has_word || i_in_text_end);
    assign o_cmd.bank   = r_bank;
    assign o_cmd.sep    = has_word ? sep : SEP_NONE;
    assign o_cmd.cut    = has_word && ovf_after;
    assign o_cmd.close  = i_in_text_end;
    assign o_cmd_len    = has_word ? len_after : '0;

    assign o_wr_en   = acc && wr;
    assign o_wr_addr = r_bank ? (AW'(MAX_WORD) + AW'(r_len)) : AW'(r_len);
    assign o_wr_data = i_in_ch;

    always_comb begin
        n_len  = r_len;
        n_col  = r_col;
        n_ovf  = r_ovf;
        n_bank = r_bank;
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (acc) begin
            n_len = flush ? '0 : len_after;
            n_ovf = flush ? 1'b0 : ovf_after;
            if (has_word) begin
                n_col          = col_word;
                n_bank         = ~r_bank;
                n_busy[r_bank] = 1'b1;
            end
            if (i_in_text_end) begin
                n_col = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_len        <= '0;
            r_col        <= 8'd0;
            r_ovf        <= 1'b0;
            r_bank       <= 1'b0;
            r_busy       <= 2'b00;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_data;
            end
            r_len  <= n_len;
            r_col  <= n_col;
            r_ovf  <= n_ovf;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

endmodule

FILE: rtl/core/gww_queue.sv
module gww_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/gww_back.sv
module gww_back #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF,
    localparam int LW = $clog2(MAX_WORD + 1),
    localparam int AW = $clog2(2 * MAX_WORD)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  gww_pkg::t_cmd    i_cmd,
    input  logic [LW-1:0]    i_cmd_len,
    output logic             o_pop,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [7:0]       i_rd_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_char,
    output logic             o_out_run_last,
    output logic             o_out_word_cut,
    output gww_pkg::t_rel    o_rel
);
    import gww_pkg::*;

    t_bstate       r_state, n_state;
    t_cmd          r_cmd;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          r_ov;
    logic [7:0]    r_ochar;
    logic          r_olast, r_ocut;

    logic          can_adv, last_byte, emit, e_last, e_cut;
    logic [7:0]    e_char;

    assign can_adv   = !r_ov || i_out_ready;
    assign last_byte = (r_rd_idx == r_len);
    assign o_rd_addr = r_cmd.bank ? (AW'(MAX_WORD) + AW'(r_rd_idx)) : AW'(r_rd_idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.sep != SEP_NONE) begin
                        n_state = BS_SEP;
                    end else if (i_cmd_len != '0) begin
                        n_state = BS_WORD;
                    end else begin
                        n_state = BS_CLOSE;
                    end
                end
            end
            BS_SEP: begin
                if (can_adv) begin
                    n_state = BS_WORD;
                end
            end
            BS_WORD: begin
                if (r_rd_vld && can_adv && last_byte) begin
                    n_state = r_cmd.close ? BS_CLOSE : BS_IDLE;
                end
            end
            BS_CLOSE: begin
                if (can_adv) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_rd_en     = 1'b0;
        emit        = 1'b0;
        e_char      = BREAK_BYTE;
        e_last      = 1'b0;
        e_cut       = 1'b0;
        o_rel.valid = 1'b0;
        o_rel.bank  = r_cmd.bank;
        case (r_state)
            BS_IDLE: begin
                o_pop = !i_q_empty;
            end
            BS_SEP: begin
                o_rd_en = can_adv;
                emit    = can_adv;
                e_char  = (r_cmd.sep == SEP_SPACE) ? SPACE_BYTE : BREAK_BYTE;
                e_cut   = r_cmd.cut;
            end
            BS_WORD: begin
                o_rd_en     = (!r_rd_vld || can_adv) && !last_byte;
                emit        = r_rd_vld && can_adv;
                e_char      = i_rd_data;
                e_last      = last_byte && !r_cmd.close;
                e_cut       = r_cmd.cut;
                o_rel.valid = emit && last_byte;
            end
            BS_CLOSE: begin
                emit   = can_adv;
                e_last = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_cmd;
            r_len    <= i_cmd_len;
            r_rd_idx <= '0;
        end else if (o_rd_en) begin
            r_rd_idx <= r_rd_idx + LW'(1);
        end
        if (emit) begin
            r_ochar <= e_char;
            r_olast <= e_last;
            r_ocut  <= e_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_rd_vld <= 1'b0;
            end else if (o_rd_en) begin
                r_rd_vld <= 1'b1;
            end else if (emit && r_state == BS_WORD) begin
                r_rd_vld <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_char     = r_ochar;
    assign o_out_run_last = r_olast;
    assign o_out_word_cut = r_ocut;

endmodule

FILE: rtl/core/gww_checker.sv
`include "greedy_word_wrap_top_assert.svh"

module gww_top_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_run_last,
    input logic       i_out_word_cut
);
    import gww_pkg::*;

    logic [9:0] out_word;

    assign out_word = {i_out_char, i_out_run_last, i_out_word_cut};

    `GWW_AST_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(out_word))
    `GWW_AST_IMP(a_space_not_last, i_out_valid && i_out_ready && i_out_char == SPACE_BYTE, !i_out_run_last)
    `GWW_AST_IMP(a_quiet_after_reset, $past(!i_rst_n), !i_out_valid)

endmodule

bind greedy_word_wrap_top gww_top_checker u_gww_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_run_last (o_out.run_last),
    .i_out_word_cut (o_out.word_cut)
);
